### design/sqltl_pkg.sv
// Shared types, constants and helpers of the SQL token lexer.
package sqltl_pkg;

    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;
    localparam int MAX_TOK = 3;

    localparam logic [4:0] K_IDENT   = 5'd0;
    localparam logic [4:0] K_NUMBER  = 5'd1;
    localparam logic [4:0] K_STRING  = 5'd2;
    localparam logic [4:0] K_SELECT  = 5'd3;
    localparam logic [4:0] K_FROM    = 5'd4;
    localparam logic [4:0] K_INSERT  = 5'd5;
    localparam logic [4:0] K_INTO    = 5'd6;
    localparam logic [4:0] K_CREATE  = 5'd7;
    localparam logic [4:0] K_TABLE   = 5'd8;
    localparam logic [4:0] K_INT     = 5'd9;
    localparam logic [4:0] K_VARCHAR = 5'd10;
    localparam logic [4:0] K_BOOL    = 5'd11;
    localparam logic [4:0] K_TRUE    = 5'd12;
    localparam logic [4:0] K_FALSE   = 5'd13;
    localparam logic [4:0] K_VALUES  = 5'd14;
    localparam logic [4:0] K_WHERE   = 5'd15;
    localparam logic [4:0] K_STAR    = 5'd16;
    localparam logic [4:0] K_SEMI    = 5'd17;
    localparam logic [4:0] K_LPAREN  = 5'd18;
    localparam logic [4:0] K_RPAREN  = 5'd19;
    localparam logic [4:0] K_COMMA   = 5'd20;
    localparam logic [4:0] K_LT      = 5'd21;
    localparam logic [4:0] K_LE      = 5'd22;
    localparam logic [4:0] K_GT      = 5'd23;
    localparam logic [4:0] K_GE      = 5'd24;
    localparam logic [4:0] K_NEQ     = 5'd25;
    localparam logic [4:0] K_EQ      = 5'd26;
    localparam logic [4:0] K_ERROR   = 5'd27;
    localparam logic [4:0] K_END     = 5'd28;

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_WORD = 3'd1,
        M_NUM  = 3'd2,
        M_STR  = 3'd3,
        M_LT   = 3'd4,
        M_GT   = 3'd5,
        M_BANG = 3'd6,
        M_HALT = 3'd7
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       final_byte;
    } t_byte;

    typedef struct packed {
        logic [4:0]  tok_kind;
        logic [15:0] tok_start;
        logic [15:0] tok_len;
        logic        run_last;
    } t_tok;

    // Tokens produced by one byte, handed from the lexer to the token queue.
    typedef struct packed {
        logic [1:0]           cnt;
        t_tok [MAX_TOK-1:0]   tok;
    } t_tok_grp;

    function automatic logic [15:0] clip(input logic [POS_BITS-1:0] v);
        logic [31:0] w;
        begin
            w = 32'(v);
            return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
        end
    endfunction

endpackage

### design/sql_token_lexer.sv
// Top level of the streaming SQL token lexer.
//
// The lexer takes one byte of SQL text per transaction, with final_byte set on
// the last byte of a statement, and delivers tokens as kind, start offset and
// length through a queue-style result port. Whitespace separates tokens;
// identifiers, numbers, fifteen case-insensitive keyword spellings, quoted
// strings (reported without quotes) and one- or two-byte symbols are
// recognized. An unexpected byte or a '!' not followed by '=' produces a single
// error token, after which bytes are ignored until the final byte, which always
// adds an end token with run_last set and restarts offsets at zero. A byte is
// accepted in every cycle in which the token queue has room for three tokens,
// so a steady stream runs at one byte per clock; the queue holds eight tokens
// and the result side drains one token per clock, so the sustained rate falls
// below one byte per cycle only when the text produces tokens faster than
// they are popped. A token with no older token still queued becomes visible
// on the result port in the cycle after the byte that completes it is
// accepted. There is no configuration and no clearing pass after reset.
module sql_token_lexer
    import sqltl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  push,
    output logic  full,
    input  t_byte i_byte,
    output logic  empty,
    input  logic  pop,
    output t_tok  o_token
);

    t_tok_grp grp;
    logic     acc;

    // A byte transaction completes only while the queue can absorb its tokens.
    assign acc = push && !full;

    sqltl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_byte  (i_byte),
        .o_grp   (grp)
    );

    sqltl_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_grp   (grp),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_tok   (o_token)
    );

endmodule

### design/sqltl_front.sv
// Byte classifier and lexer state machine; emits up to three tokens per byte.
module sqltl_front
    import sqltl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_acc,
    input  t_byte    i_byte,
    output t_tok_grp o_grp
);

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    t_mode               r_mode, n_mode;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_begin, n_begin;
    logic [55:0]         r_prefix, n_prefix;
    logic [3:0]          r_count, n_count;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic [4:0] word_kind(input logic [55:0] p, input logic [3:0] n);
        logic [4:0] k;
        begin
            k = K_IDENT;
            if (n == 4'd6 && p == 56'("SELECT"))  k = K_SELECT;
            if (n == 4'd4 && p == 56'("FROM"))    k = K_FROM;
            if (n == 4'd6 && p == 56'("INSERT"))  k = K_INSERT;
            if (n == 4'd4 && p == 56'("INTO"))    k = K_INTO;
            if (n == 4'd6 && p == 56'("CREATE"))  k = K_CREATE;
            if (n == 4'd5 && p == 56'("TABLE"))   k = K_TABLE;
            if (n == 4'd3 && p == 56'("INT"))     k = K_INT;
            if (n == 4'd7 && p == 56'("INTEGER")) k = K_INT;
            if (n == 4'd7 && p == 56'("VARCHAR")) k = K_VARCHAR;
            if (n == 4'd4 && p == 56'("BOOL"))    k = K_BOOL;
            if (n == 4'd7 && p == 56'("BOOLEAN")) k = K_BOOL;
            if (n == 4'd4 && p == 56'("TRUE"))    k = K_TRUE;
            if (n == 4'd5 && p == 56'("FALSE"))   k = K_FALSE;
            if (n == 4'd6 && p == 56'("VALUES"))  k = K_VALUES;
            if (n == 4'd5 && p == 56'("WHERE"))   k = K_WHERE;
            return k;
        end
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    function automatic logic [15:0] span(input logic [POS_BITS-1:0] e,
                                         input logic [POS_BITS-1:0] b);
        return clip((e > b) ? e - b : '0);
    endfunction

    function automatic t_tok mk(input logic [4:0] kind, input logic [15:0] start,
                                input logic [15:0] len, input logic last);
        t_tok t;
        begin
            t.tok_kind  = kind;
            t.tok_start = start;
            t.tok_len   = len;
            t.run_last  = last;
            return t;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_begin  <= '0;
            r_prefix <= '0;
            r_count  <= '0;
        end else if (i_acc) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_begin  <= n_begin;
            r_prefix <= n_prefix;
            r_count  <= n_count;
        end
    end

    always_comb begin
        logic [7:0]          c;
        logic [POS_BITS-1:0] cur;
        logic [POS_BITS-1:0] nxt;
        logic                do_start;
        logic [1:0]          k;
        t_tok [MAX_TOK-1:0]  tv;

        c        = i_byte.ch;
        cur      = r_pos;
        nxt      = sat_inc(cur);
        do_start = 1'b0;
        k        = 2'd0;
        tv       = '0;
        n_mode   = r_mode;
        n_pos    = nxt;
        n_begin  = r_begin;
        n_prefix = r_prefix;
        n_count  = r_count;

        // Close or extend the token that was open before this byte.
        case (r_mode)
            M_WORD: begin
                if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                    if (r_count < 4'd7) begin
                        n_prefix = {r_prefix[47:0], upper(c)};
                    end
                    if (r_count < 4'd8) begin
                        n_count = r_count + 4'd1;
                    end
                end else begin
                    tv[k] = mk(word_kind(r_prefix, r_count), clip(r_begin),
                               span(cur, r_begin), 1'b0);
                    k = k + 2'd1;
                    do_start = 1'b1;
                end
            end
            M_NUM: begin
                if (!is_digit(c)) begin
                    tv[k] = mk(K_NUMBER, clip(r_begin), span(cur, r_begin), 1'b0);
                    k = k + 2'd1;
                    do_start = 1'b1;
                end
            end
            M_STR: begin
                if (c == CH_QUOTE) begin
                    tv[k] = mk(K_STRING, clip(r_begin), span(cur, r_begin), 1'b0);
                    k = k + 2'd1;
                    n_mode = M_IDLE;
                end
            end
            M_LT, M_GT: begin
                if (c == CH_EQ) begin
                    tv[k] = mk((r_mode == M_LT) ? K_LE : K_GE, clip(r_begin), 16'd2, 1'b0);
                    k = k + 2'd1;
                    n_mode = M_IDLE;
                end else begin
                    tv[k] = mk((r_mode == M_LT) ? K_LT : K_GT, clip(r_begin), 16'd1, 1'b0);
                    k = k + 2'd1;
                    do_start = 1'b1;
                end
            end
            M_BANG: begin
                if (c == CH_EQ) begin
                    tv[k] = mk(K_NEQ, clip(r_begin), 16'd2, 1'b0);
                    n_mode = M_IDLE;
                end else begin
                    tv[k] = mk(K_ERROR, clip(r_begin), 16'd1, 1'b0);
                    n_mode = M_HALT;
                end
                k = k + 2'd1;
            end
            M_HALT: begin
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        // Begin a new token with this byte.
        if (do_start) begin
            n_mode = M_IDLE;
            if (is_space(c)) begin
            end else if (is_alpha(c) || c == CH_UNDER) begin
                n_mode   = M_WORD;
                n_begin  = cur;
                n_prefix = {48'd0, upper(c)};
                n_count  = 4'd1;
            end else if (is_digit(c)) begin
                n_mode  = M_NUM;
                n_begin = cur;
            end else begin
                case (c)
                    CH_QUOTE: begin
                        n_mode  = M_STR;
                        n_begin = nxt;
                    end
                    CH_STAR: begin
                        tv[k] = mk(K_STAR, clip(cur), 16'd1, 1'b0);
                        k = k + 2'd1;
                    end
                    CH_SEMI: begin
                        tv[k] = mk(K_SEMI, clip(cur), 16'd1, 1'b0);
                        k = k + 2'd1;
                    end
                    CH_LPAREN: begin
                        tv[k] = mk(K_LPAREN, clip(cur), 16'd1, 1'b0);
                        k = k + 2'd1;
                    end
                    CH_RPAREN: begin
                        tv[k] = mk(K_RPAREN, clip(cur), 16'd1, 1'b0);
                        k = k + 2'd1;
                    end
                    CH_COMMA: begin
                        tv[k] = mk(K_COMMA, clip(cur), 16'd1, 1'b0);
                        k = k + 2'd1;
                    end
                    CH_EQ: begin
                        tv[k] = mk(K_EQ, clip(cur), 16'd1, 1'b0);
                        k = k + 2'd1;
                    end
                    CH_LT: begin
                        n_mode  = M_LT;
                        n_begin = cur;
                    end
                    CH_GT: begin
                        n_mode  = M_GT;
                        n_begin = cur;
                    end
                    CH_BANG: begin
                        n_mode  = M_BANG;
                        n_begin = cur;
                    end
                    default: begin
                        tv[k] = mk(K_ERROR, clip(cur), 16'd1, 1'b0);
                        k = k + 2'd1;
                        n_mode = M_HALT;
                    end
                endcase
            end
        end

        // The final byte flushes any open token, appends the end token and
        // returns the lexer to its reset state.
        if (i_byte.final_byte) begin
            case (n_mode)
                M_WORD: begin
                    tv[k] = mk(word_kind(n_prefix, n_count), clip(n_begin),
                               span(nxt, n_begin), 1'b0);
                    k = k + 2'd1;
                end
                M_NUM: begin
                    tv[k] = mk(K_NUMBER, clip(n_begin), span(nxt, n_begin), 1'b0);
                    k = k + 2'd1;
                end
                M_STR: begin
                    tv[k] = mk(K_STRING, clip(n_begin), span(nxt, n_begin), 1'b0);
                    k = k + 2'd1;
                end
                M_LT: begin
                    tv[k] = mk(K_LT, clip(n_begin), 16'd1, 1'b0);
                    k = k + 2'd1;
                end
                M_GT: begin
                    tv[k] = mk(K_GT, clip(n_begin), 16'd1, 1'b0);
                    k = k + 2'd1;
                end
                M_BANG: begin
                    tv[k] = mk(K_ERROR, clip(n_begin), 16'd1, 1'b0);
                    k = k + 2'd1;
                end
                default: begin
                end
            endcase
            tv[k] = mk(K_END, clip(nxt), 16'd0, 1'b1);
            k = k + 2'd1;
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_begin  = '0;
            n_prefix = '0;
            n_count  = '0;
        end

        o_grp.tok = tv;
        o_grp.cnt = i_acc ? k : 2'd0;
    end

endmodule

### design/sqltl_tokq.sv
// Token queue: takes up to three tokens per cycle, delivers one per pop.
module sqltl_tokq
    import sqltl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tok_grp i_grp,
    output logic     o_full,
    output logic     o_empty,
    input  logic     i_pop,
    output t_tok     o_tok
);

    t_tok             mem [QDEPTH];
    logic [QAW-1:0]   r_wr, n_wr;
    logic [QAW-1:0]   r_rd, n_rd;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             pop_ok;

    assign o_empty = (r_cnt == '0);
    // Room is required for the worst case of one byte.
    assign o_full  = (r_cnt > QCW'(QDEPTH - MAX_TOK));
    assign o_tok   = mem[r_rd];
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr + QAW'(i_grp.cnt);
        n_rd  = r_rd + QAW'(pop_ok);
        n_cnt = r_cnt + QCW'(i_grp.cnt) - QCW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_TOK; i++) begin
            if (2'(i) < i_grp.cnt) begin
                mem[r_wr + QAW'(i)] <= i_grp.tok[i];
            end
        end
    end

endmodule
